// File: hdl/compacting_list_append_remove_defines.svh
// Assertion macros for the compacting list store.
`ifndef COMPACTING_LIST_APPEND_REMOVE_DEFINES_SVH
`define COMPACTING_LIST_APPEND_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent
`define CLAR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compacting list assertion failed");
// Consequent holds in the cycle after the antecedent
`define CLAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compacting list assertion failed");
`else
`define CLAR_ASSERT_SAME(lbl, ante, cons)
`define CLAR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/clar_pkg.sv
package clar_pkg;

  // Store geometry
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_REMOVED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ELEMENT  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [3:0]         position;
    logic [4:0]         fill;
    logic               last;
  } out_result_t;

  // Store port request from the sequencer
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
    idx_t  rd_addr;
  } mem_req_t;

  // Item value to stored word (low WIDTH bits)
  function automatic word_t to_word(logic [31:0] v);
    logic [63:0] t;
    t = {32'd0, v};
    return t[WIDTH-1:0];
  endfunction

  // Stored word to element field
  function automatic logic [31:0] from_word(word_t w);
    logic [63:0] t;
    t = 64'(w);
    return t[31:0];
  endfunction

  function automatic logic [3:0] pos_of(idx_t i);
    logic [63:0] t;
    t = 64'(i);
    return t[3:0];
  endfunction

  function automatic logic [4:0] fill_of(cnt_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[4:0];
  endfunction

endpackage

// File: hdl/clar_store.sv
// Element store: one write port, one registered read port
module clar_store (
  input  logic              clk,
  input  clar_pkg::mem_req_t req,
  output clar_pkg::word_t   rd_data
);

  clar_pkg::word_t mem [clar_pkg::DEPTH];

  // Write transfer
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read, issued every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

// File: hdl/clar_ctrl.sv
// Sequencer: walks the store one entry a cycle through a single comparator
module clar_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  clar_pkg::in_item_t    in_item,
  input  clar_pkg::word_t       rd_data,
  output clar_pkg::mem_req_t    req,
  output logic                  busy,
  output logic                  res_valid,
  output clar_pkg::out_result_t res,
  output clar_pkg::cnt_t        fill_cnt
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  localparam clar_pkg::cnt_t CNT_FULL = clar_pkg::CNT_W'(clar_pkg::DEPTH);
  localparam clar_pkg::cnt_t CNT_ONE  = clar_pkg::CNT_W'(1);
  localparam clar_pkg::idx_t IDX_ONE  = clar_pkg::IDX_W'(1);

  logic [1:0]      state_r, state_nxt;
  clar_pkg::cnt_t  count_r, count_nxt;
  clar_pkg::idx_t  idx_r, idx_nxt;
  clar_pkg::idx_t  at_r, at_nxt;
  clar_pkg::word_t key_r, key_nxt;
  logic [31:0]     val_r, val_nxt;

  logic            more;
  logic            hit;
  clar_pkg::idx_t  idx_step;

  // Shared compare unit and walk bookkeeping
  assign hit      = (rd_data == key_r);
  assign more     = (clar_pkg::CNT_W'(idx_r) + CNT_ONE) < count_r;
  assign idx_step = idx_r + IDX_ONE;

  // Next state, store requests and results
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = '0;
    at_nxt      = at_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    req.wr_en   = 1'b0;
    req.wr_addr = '0;
    req.wr_data = '0;
    res_valid   = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    res.element = val_r;
    res.fill    = clar_pkg::fill_of(count_r);

    case (state_r)
      S_IDLE: begin
        res.element = in_item.item_value;
        if (start) begin
          case (in_item.op)
            clar_pkg::OP_APPEND: begin
              res_valid = 1'b1;
              if (count_r == CNT_FULL) begin
                res.status = clar_pkg::ST_FULL;
              end else begin
                req.wr_en    = 1'b1;
                req.wr_addr  = count_r[clar_pkg::IDX_W-1:0];
                req.wr_data  = clar_pkg::to_word(in_item.item_value);
                count_nxt    = count_r + CNT_ONE;
                res.status   = clar_pkg::ST_APPENDED;
                res.position = clar_pkg::pos_of(count_r[clar_pkg::IDX_W-1:0]);
                res.fill     = clar_pkg::fill_of(count_r + CNT_ONE);
              end
            end
            clar_pkg::OP_REMOVE: begin
              key_nxt = clar_pkg::to_word(in_item.item_value);
              val_nxt = in_item.item_value;
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res.status = clar_pkg::ST_NOTFOUND;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            clar_pkg::OP_DUMP: begin
              val_nxt = in_item.item_value;
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res.status = clar_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Compare entry idx_r against the key
      S_SRCH: begin
        if (hit) begin
          at_nxt = idx_r;
          if (more) begin
            state_nxt = S_SHIFT;
            idx_nxt   = idx_step;
          end else begin
            state_nxt    = S_IDLE;
            count_nxt    = count_r - CNT_ONE;
            res_valid    = 1'b1;
            res.status   = clar_pkg::ST_REMOVED;
            res.position = clar_pkg::pos_of(idx_r);
            res.fill     = clar_pkg::fill_of(count_r - CNT_ONE);
          end
        end else if (more) begin
          idx_nxt = idx_step;
        end else begin
          state_nxt  = S_IDLE;
          res_valid  = 1'b1;
          res.status = clar_pkg::ST_NOTFOUND;
        end
      end

      // Move entry idx_r down by one place
      S_SHIFT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_r - IDX_ONE;
        req.wr_data = rd_data;
        if (more) begin
          idx_nxt = idx_step;
        end else begin
          state_nxt    = S_IDLE;
          count_nxt    = count_r - CNT_ONE;
          res_valid    = 1'b1;
          res.status   = clar_pkg::ST_REMOVED;
          res.position = clar_pkg::pos_of(at_r);
          res.fill     = clar_pkg::fill_of(count_r - CNT_ONE);
        end
      end

      // One element per cycle
      S_DUMP: begin
        res_valid    = 1'b1;
        res.status   = clar_pkg::ST_ELEMENT;
        res.element  = clar_pkg::from_word(rd_data);
        res.position = clar_pkg::pos_of(idx_r);
        res.last     = !more;
        if (more) begin
          idx_nxt = idx_step;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Read address follows the next walk index
    req.rd_addr = idx_nxt;
  end

  assign busy     = (state_r != S_IDLE);
  assign fill_cnt = count_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    at_r  <= at_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

// File: hdl/compacting_list_append_remove.sv
// Append: result registered and shown in the cycle after the transfer; busy stays low.
// Remove: searches from entry 0 to the match, then moves each later entry down; result registered.
// Dump: through the dump state and result register, one element per cycle on a single read port.
// Results cannot be stalled; each shows for one cycle with out_valid.
// Synchronous active-low reset empties the list; entry contents are kept.
`include "compacting_list_append_remove_defines.svh"

module compacting_list_append_remove (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  clar_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output clar_pkg::out_result_t out_result
);

  clar_pkg::mem_req_t    req;
  clar_pkg::word_t       rd_data;
  logic                  res_valid;
  clar_pkg::out_result_t res;
  clar_pkg::cnt_t        fill_cnt;

  logic                  out_valid_r;
  clar_pkg::out_result_t out_result_r;

  clar_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  clar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .rd_data   (rd_data),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .fill_cnt  (fill_cnt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= res;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Checks
  `CLAR_ASSERT_SAME(a_fill_range, 1'b1, fill_cnt <= clar_pkg::CNT_W'(clar_pkg::DEPTH))
  `CLAR_ASSERT_NEXT(a_dump_cont, out_valid && !out_result.last, out_valid)
  `CLAR_ASSERT_SAME(a_res_cause, out_valid, $past(busy) || $past(start))

endmodule
